>>> rtl/core/wsfd_pkg.sv
// Shared types and constants of the WebSocket frame decoder.
package wsfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenBits = 32;          // widest payload length kept
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CntW    = 3;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OpcW    = 4;
  localparam int unsigned OutDataW = 48;         // 46 field bits padded to bytes

  localparam logic [ByteW-1:0]   RsvMask   = 8'h70;
  localparam logic [6:0]         Len16Code = 7'd126;
  localparam logic [6:0]         Len64Code = 7'd127;
  localparam logic [LenBits-1:0] MaxLenRst = 32'(4 * 1024 * 1024);

  typedef enum logic [KindW-1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindError   = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PhHdr0    = 6'b000001,
    PhHdr1    = 6'b000010,
    PhExtLen  = 6'b000100,
    PhMask    = 6'b001000,
    PhPayload = 6'b010000,
    PhError   = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e              kind;
    logic               fin;
    logic [OpcW-1:0]    opcode;
    logic               masked;
    logic [LenBits-1:0] len;
    logic [ByteW-1:0]   pbyte;
    logic               last;
  } res_t;

endpackage

>>> rtl/core/websocket_frame_decoder.sv
// Top level of the WebSocket frame decoder: header parser, unmasking and output skid.
//
// Usage:
//   s_axis: one stream byte per item in tdata; tuser high resynchronises the
//   parser (partial frame dropped, error cleared, byte ignored, no result).
//   m_axis: at most one result per input item. tuser carries the kind
//   (header, payload byte, error), tlast marks the final result of a frame.
//   cfg: write of the maximum payload length, taken in any cycle.
//   The result of an accepted byte is registered before it reaches m_axis.
//   Throughput is one byte per clock while the skid entry is empty: the parser
//   state updates in the cycle a byte is accepted and the result lands in a
//   registered output stage backed by a one-entry skid buffer.
//   When the receiver stalls, the output holds and the skid entry catches one
//   more result; s_axis_tready_o drops only while the skid entry is full.
//   After a length or RSV error the parser discards bytes until a resync.
//   Reset (rst_ni low, asynchronous) empties both output entries, puts the
//   parser at the first header byte and sets the limit to 4 MiB.
module websocket_frame_decoder
  import wsfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] stream_byte
  input  logic                s_axis_tuser_i,   // [0] resync
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] fin, [4:1] frame_opcode, [5] was_masked, [37:6] payload_length,
  // [45:38] payload_byte, [47:46] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [KindW-1:0]    m_axis_tuser_o,   // [1:0] kind
  output logic                m_axis_tlast_o,   // last_of_frame
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LenBits-1:0]  cfg_data_i
);

  phase_e             phase_q, phase_d;
  logic               fin_q, fin_d;
  logic [OpcW-1:0]    opc_q, opc_d;
  logic               mask_q, mask_d;
  logic [LenBits-1:0] acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [LenBits-1:0] rem_q, rem_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [LenBits-1:0] max_q;

  logic               accept;
  logic               len_done;
  logic               res_vld;
  res_t               res;
  logic [ByteW-1:0]   key_byte;
  logic [ByteW-1:0]   b;

  res_t               out_q, skid_q;
  logic               out_vld_q, skid_vld_q;
  logic               pop;

  assign b           = s_axis_tdata_i;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = !skid_vld_q;
  assign accept      = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxLenRst;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // mask key byte for the current payload index, most significant first
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    opc_d    = opc_q;
    mask_d   = mask_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    rem_d    = rem_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    len_done = 1'b0;
    res_vld  = 1'b0;
    res      = '0;

    if (accept) begin
      if (s_axis_tuser_i) begin
        phase_d = PhHdr0;
        fin_d   = 1'b0;
        opc_d   = '0;
        mask_d  = 1'b0;
        acc_d   = '0;
        ovf_d   = 1'b0;
        rem_d   = '0;
        key_d   = '0;
        cnt_d   = '0;
      end else begin
        unique case (phase_q)
          PhHdr0: begin
            if ((b & RsvMask) != '0) begin
              phase_d    = PhError;
              res_vld    = 1'b1;
              res.kind   = KindError;
              res.last   = 1'b1;
            end else begin
              fin_d   = b[7];
              opc_d   = b[3:0];
              mask_d  = 1'b0;
              key_d   = '0;
              acc_d   = '0;
              ovf_d   = 1'b0;
              rem_d   = '0;
              cnt_d   = '0;
              phase_d = PhHdr1;
            end
          end
          PhHdr1: begin
            mask_d = b[7];
            acc_d  = '0;
            ovf_d  = 1'b0;
            if (b[6:0] == Len16Code) begin
              phase_d = PhExtLen;
              cnt_d   = CntW'(1);
            end else if (b[6:0] == Len64Code) begin
              phase_d = PhExtLen;
              cnt_d   = CntW'(7);
            end else begin
              acc_d    = LenBits'(b[6:0]);
              len_done = 1'b1;
            end
          end
          PhExtLen: begin
            // bits shifted out of the kept width make the frame too long
            ovf_d = ovf_q || (acc_q[LenBits-1 -: ByteW] != '0);
            acc_d = {acc_q[LenBits-ByteW-1:0], b};
            if (cnt_q == '0) begin
              len_done = 1'b1;
            end else begin
              cnt_d = cnt_q - CntW'(1);
            end
          end
          PhMask: begin
            key_d = {key_q[KeyW-ByteW-1:0], b};
            cnt_d = cnt_q + CntW'(1);
            if (cnt_q == CntW'(3)) begin
              cnt_d      = '0;
              res_vld    = 1'b1;
              res.kind   = KindHeader;
              res.fin    = fin_q;
              res.opcode = opc_q;
              res.masked = mask_q;
              res.len    = acc_q;
              res.last   = (rem_q == '0);
              phase_d    = (rem_q == '0) ? PhHdr0 : PhPayload;
            end
          end
          PhPayload: begin
            cnt_d      = {1'b0, cnt_q[1:0] + 2'd1};
            rem_d      = rem_q - LenBits'(1);
            res_vld    = 1'b1;
            res.kind   = KindPayload;
            res.fin    = fin_q;
            res.opcode = opc_q;
            res.masked = mask_q;
            res.len    = acc_q;
            res.pbyte  = b ^ key_byte;
            res.last   = (rem_q == LenBits'(1));
            if (rem_q == LenBits'(1)) begin
              phase_d = PhHdr0;
            end
          end
          PhError: begin
          end
          default: begin
            phase_d = PhHdr0;
          end
        endcase

        if (len_done) begin
          if (ovf_d || (acc_d > max_q)) begin
            phase_d = PhError;
            res_vld = 1'b1;
            res     = '0;
            res.kind = KindError;
            res.last = 1'b1;
          end else begin
            rem_d = acc_d;
            cnt_d = '0;
            if (mask_d) begin
              phase_d = PhMask;
            end else begin
              res_vld    = 1'b1;
              res.kind   = KindHeader;
              res.fin    = fin_d;
              res.opcode = opc_d;
              res.masked = 1'b0;
              res.len    = acc_d;
              res.last   = (acc_d == '0);
              phase_d    = (acc_d == '0) ? PhHdr0 : PhPayload;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr0;
      fin_q   <= 1'b0;
      opc_q   <= '0;
      mask_q  <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
      key_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      opc_q   <= opc_d;
      mask_q  <= mask_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
    end
  end

  // output register with a one-entry skid behind it
  assign pop = out_vld_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (res_vld) begin
      if (out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (res_vld) begin
      if (out_vld_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {2'b00, out_q.pbyte, out_q.len, out_q.masked,
                            out_q.opcode, out_q.fin};

endmodule

>>> rtl/core/wsfd_checker.sv
// Port-level checks of the WebSocket frame decoder and their binding.
module wsfd_checker
  import wsfd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic [KindW-1:0]    m_axis_tuser_o,
  input logic                m_axis_tlast_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // input back-pressure only with a result pending
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KindError) |->
      (m_axis_tdata_o == '0) && m_axis_tlast_o)
    else $error("error result not clean");

  // header closes the frame exactly when the length is zero
  a_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KindHeader) |->
      (m_axis_tlast_o == (m_axis_tdata_o[37:6] == '0))
      && (m_axis_tdata_o[45:38] == '0))
    else $error("header result inconsistent");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (.*);
